// ----- src/list_update_event_coalescer_top_assert.svh -----
// Assertion macros for the list update event coalescer.
`ifndef LIST_UPDATE_EVENT_COALESCER_TOP_ASSERT_SVH
`define LIST_UPDATE_EVENT_COALESCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define LUEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("coalescer check failed");

// Consequent must hold in the cycle after the antecedent.
`define LUEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("coalescer check failed");

`else

`define LUEC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LUEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/luec_pkg.sv -----
`default_nettype none

package luec_pkg;

	localparam int POSITION_BITS_DEF = 16;

	// Operation codes on the input side
	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_MOVE   = 3'd2;
	localparam logic [2:0] OP_CHANGE = 3'd3;
	localparam logic [2:0] OP_FLUSH  = 3'd4;

	// Pending event kinds; the low two bits match the output kind
	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_REMOVE = 3'd1;
	localparam logic [2:0] KIND_MOVE   = 3'd2;
	localparam logic [2:0] KIND_CHANGE = 3'd3;
	localparam logic [2:0] KIND_NONE   = 3'd4;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] position;
		logic [15:0] amount;
		logic [15:0] payload_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [15:0] event_position;
		logic [15:0] event_amount;
		logic [15:0] event_payload;
	} rsp_t;

endpackage

`default_nettype wire

// ----- src/list_update_event_coalescer_top.sv -----
// List update event coalescer.
// Input channel (req_valid / req_stall / req) carries list edit events:
// insert, remove, move, change, or flush. One event is held pending; events
// that extend it are merged into it, any other valid event sends the pending
// event, if one is held, out on the result channel (rsp_valid / rsp_stall /
// rsp) and takes its place. A flush sends the pending event and leaves
// nothing pending; codes above flush are dropped. An item is captured in an
// input register, then the combinational merge logic compares it with the
// pending registers and loads the result register with any emitted event.
// Throughput is one item per cycle unless an emitting item waits on a stalled
// result: the input register drains whenever the result register is empty or
// being taken, or when the item does not emit. While rsp_stall is high the
// result holds; an item that merges still moves on, and req_stall rises only
// when an item that must emit is waiting. Reset clears the pending event to
// none and empties both registers. Positions and counts are POSITION_BITS
// wide internally; merged counts saturate at the largest value.
`default_nettype none

module list_update_event_coalescer_top #(
	parameter int POSITION_BITS = luec_pkg::POSITION_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire luec_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output luec_pkg::rsp_t     rsp
);

	localparam int SW = POSITION_BITS + 1;
	localparam logic [POSITION_BITS-1:0] CNT_MAX = {POSITION_BITS{1'b1}};

	// Input register
	logic                     valid_s1;
	logic [2:0]               op_s1;
	logic [POSITION_BITS-1:0] pos_s1;
	logic [POSITION_BITS-1:0] amt_s1;
	logic [15:0]              tag_s1;

	// Pending event
	logic [2:0]               pend_kind_q;
	logic [POSITION_BITS-1:0] pend_pos_q;
	logic [POSITION_BITS-1:0] pend_amt_q;
	logic [15:0]              pend_pay_q;

	logic                     out_valid_q;
	luec_pkg::rsp_t           out_q;

	logic [SW-1:0] pend_end, new_end, cnt_sum, chg_end, chg_len;
	logic [POSITION_BITS-1:0] chg_start, cnt_sat, len_sat;
	logic merge_ins, merge_rem, merge_chg, merged, op_ok, s1_emit, s1_fire, out_ready;
	logic s1_take;

	assign pend_end = {1'b0, pend_pos_q} + {1'b0, pend_amt_q};
	assign new_end  = {1'b0, pos_s1} + {1'b0, amt_s1};
	assign cnt_sum  = {1'b0, pend_amt_q} + {1'b0, amt_s1};
	assign cnt_sat  = cnt_sum[SW-1] ? CNT_MAX : cnt_sum[POSITION_BITS-1:0];

	assign chg_start = (pos_s1 < pend_pos_q) ? pos_s1 : pend_pos_q;
	assign chg_end   = (new_end > pend_end) ? new_end : pend_end;
	assign chg_len   = chg_end - {1'b0, chg_start};
	assign len_sat   = chg_len[SW-1] ? CNT_MAX : chg_len[POSITION_BITS-1:0];

	assign merge_ins = (op_s1 == luec_pkg::OP_INSERT) && (pend_kind_q == luec_pkg::KIND_INSERT)
		&& (pos_s1 >= pend_pos_q) && ({1'b0, pos_s1} <= pend_end);
	assign merge_rem = (op_s1 == luec_pkg::OP_REMOVE) && (pend_kind_q == luec_pkg::KIND_REMOVE)
		&& (pend_pos_q >= pos_s1) && ({1'b0, pend_pos_q} <= new_end);
	assign merge_chg = (op_s1 == luec_pkg::OP_CHANGE) && (pend_kind_q == luec_pkg::KIND_CHANGE)
		&& ({1'b0, pos_s1} <= pend_end) && (new_end >= {1'b0, pend_pos_q})
		&& (tag_s1 == pend_pay_q);
	assign merged = merge_ins || merge_rem || merge_chg;

	// Codes above flush are dropped with no effect
	assign op_ok   = (op_s1 <= luec_pkg::OP_FLUSH);
	assign s1_emit = op_ok && !merged && (pend_kind_q != luec_pkg::KIND_NONE);

	assign out_ready = !out_valid_q || !rsp_stall;
	assign s1_fire   = valid_s1 && (!s1_emit || out_ready);
	assign s1_take   = !valid_s1 || s1_fire;
	assign req_stall = !s1_take;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_take) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && req_valid) begin
			op_s1  <= req.operation;
			pos_s1 <= POSITION_BITS'(req.position);
			amt_s1 <= POSITION_BITS'(req.amount);
			tag_s1 <= req.payload_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_kind_q <= luec_pkg::KIND_NONE;
			pend_pos_q  <= '0;
			pend_amt_q  <= '0;
			pend_pay_q  <= '0;
		end else if (s1_fire && op_ok) begin
			if (merge_ins) begin
				pend_amt_q <= cnt_sat;
			end else if (merge_rem) begin
				pend_amt_q <= cnt_sat;
				pend_pos_q <= pos_s1;
			end else if (merge_chg) begin
				pend_pos_q <= chg_start;
				pend_amt_q <= len_sat;
			end else if (op_s1 == luec_pkg::OP_FLUSH) begin
				pend_kind_q <= luec_pkg::KIND_NONE;
				pend_pos_q  <= '0;
				pend_amt_q  <= '0;
				pend_pay_q  <= '0;
			end else begin
				pend_kind_q <= op_s1;
				pend_pos_q  <= pos_s1;
				pend_amt_q  <= amt_s1;
				pend_pay_q  <= (op_s1 == luec_pkg::OP_CHANGE) ? tag_s1 : 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_emit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_emit) begin
			out_q.event_kind     <= pend_kind_q[1:0];
			out_q.event_position <= 16'(pend_pos_q);
			out_q.event_amount   <= 16'(pend_amt_q);
			out_q.event_payload  <= pend_pay_q;
		end
	end

`include "list_update_event_coalescer_top_assert.svh"

	`LUEC_ASSERT_NOW(a_pay_zero, clk, arst_n,
		pend_kind_q != luec_pkg::KIND_CHANGE, pend_pay_q == 16'd0)
	`LUEC_ASSERT_NOW(a_no_overrun, clk, arst_n,
		out_valid_q && rsp_stall, !(s1_fire && s1_emit))
	`LUEC_ASSERT_NEXT(a_flush_clears, clk, arst_n,
		s1_fire && op_s1 == luec_pkg::OP_FLUSH, pend_kind_q == luec_pkg::KIND_NONE)

endmodule

`default_nettype wire
